FILE: design/ffce_pkg.sv
package ffce_pkg;

  localparam int MAX_INPUTS  = 4;
  localparam int MAX_OUTPUTS = 4;
  localparam int MAX_ORDER   = 8;
  localparam int GEN_FIELD   = MAX_ORDER + 1;
  localparam int ORD_FIELD   = 4;
  localparam int STATE_W     = 32;
  localparam int CFG_DATA_W  = MAX_OUTPUTS * GEN_FIELD;
  localparam int CFG_IDX_W   = 3;
  localparam int OFF_W       = $clog2(STATE_W + 1);

  localparam logic [2:0]            RST_NUM_INPUTS  = 3'd1;
  localparam logic [2:0]            RST_NUM_OUTPUTS = 3'd2;
  localparam logic [15:0]           RST_MEM_ORDERS  = 16'h1111;

  typedef logic [MAX_ORDER-1:0]     sreg_t;
  typedef logic [ORD_FIELD-1:0]     order_t;
  typedef logic [CFG_DATA_W-1:0]    gen_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_INPUTS  = 3'd0,
    CFG_NUM_OUTPUTS = 3'd1,
    CFG_MEM_ORDERS  = 3'd2,
    CFG_GEN_INPUT0  = 3'd3,
    CFG_GEN_INPUT1  = 3'd4,
    CFG_GEN_INPUT2  = 3'd5,
    CFG_GEN_INPUT3  = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_LOAD   = 1'b1
  } opcode_t;

  // order field read as 1..MAX_ORDER
  function automatic order_t clamp_order(order_t f);
    order_t r;
    if (f == '0) begin
      r = order_t'(1);
    end else if (f > order_t'(MAX_ORDER)) begin
      r = order_t'(MAX_ORDER);
    end else begin
      r = f;
    end
    return r;
  endfunction

  function automatic sreg_t order_mask(order_t o);
    sreg_t m;
    for (int b = 0; b < MAX_ORDER; b++) begin
      m[b] = (order_t'(b) < o);
    end
    return m;
  endfunction

endpackage

FILE: design/feedforward_conv_encoder_top.sv
// Feedforward (n,k) binary convolutional encoder, up to 4 inputs and 4 outputs, memory order
// 1..8 per input. One item is accepted every clock cycle while in_stall is low: coded
// bits and packed state after the item are computed in a single pass from the input beat
// and the shift registers and are written at the accepting edge into the result register,
// which offers them in the cycle after the beat; while a stalled result holds it they go
// into a one-entry skid register, so the input side keeps taking beats, and in_stall rises
// only when both are full. Load items (opcode 1) set the shift registers from a packed word
// and return zero coded bits. Write configuration only while no results are outstanding.
module feedforward_conv_encoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ffce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [3:0]                        in_in_bits,
  input  logic [31:0]                       in_state_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_out_bits,
  output logic [31:0]                       out_packed_state
);

  localparam int NI = ffce_pkg::MAX_INPUTS;
  localparam int NO = ffce_pkg::MAX_OUTPUTS;
  localparam int GF = ffce_pkg::GEN_FIELD;
  localparam int OF = ffce_pkg::ORD_FIELD;

  // configuration registers
  logic [2:0]           num_inputs_r;
  logic [2:0]           num_outputs_r;
  logic [15:0]          mem_orders_r;
  ffce_pkg::gen_t       gen_r [NI];

  // encoder state
  ffce_pkg::sreg_t      sr_r   [NI];
  ffce_pkg::sreg_t      sr_nxt [NI];

  // result and skid registers
  logic                 out_valid_r;
  logic                 skid_valid_r;
  logic [3:0]           out_bits_r;
  logic [31:0]          out_state_r;
  logic [3:0]           skid_bits_r;
  logic [31:0]          skid_state_r;

  logic                 in_acc;
  logic                 out_free;
  logic [2:0]           k_eff;
  logic [2:0]           n_eff;
  ffce_pkg::order_t     ord  [NI];
  logic [ffce_pkg::OFF_W-1:0] off [NI];
  ffce_pkg::sreg_t      msk  [NI];
  logic [GF-1:0]        win  [NI];
  logic [3:0]           bits_nxt;
  logic [31:0]          pack_nxt;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_out_bits     = out_bits_r;
  assign out_packed_state = out_state_r;

  always_comb begin
    logic b;
    if (num_inputs_r == 3'd0) begin
      k_eff = 3'd1;
    end else if (num_inputs_r > 3'(NI)) begin
      k_eff = 3'(NI);
    end else begin
      k_eff = num_inputs_r;
    end
    if (num_outputs_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (num_outputs_r > 3'(NO)) begin
      n_eff = 3'(NO);
    end else begin
      n_eff = num_outputs_r;
    end

    for (int i = 0; i < NI; i++) begin
      ord[i] = ffce_pkg::clamp_order(mem_orders_r[OF*i +: OF]);
      msk[i] = ffce_pkg::order_mask(ord[i]);
    end
    // bit offset of each input inside the packed word
    off[0] = '0;
    for (int i = 1; i < NI; i++) begin
      off[i] = off[i-1] + ffce_pkg::OFF_W'(ord[i-1]);
    end

    for (int i = 0; i < NI; i++) begin
      win[i] = {sr_r[i] & msk[i], in_in_bits[i]};
      if (3'(i) >= k_eff) begin
        sr_nxt[i] = sr_r[i];
      end else if (in_opcode == ffce_pkg::OP_LOAD) begin
        sr_nxt[i] = ffce_pkg::sreg_t'(in_state_value >> off[i]) & msk[i];
      end else begin
        sr_nxt[i] = win[i][ffce_pkg::MAX_ORDER-1:0] & msk[i];
      end
    end

    for (int j = 0; j < NO; j++) begin
      b = 1'b0;
      for (int i = 0; i < NI; i++) begin
        if (3'(i) < k_eff) begin
          b = b ^ (^(win[i] & gen_r[i][GF*j +: GF]));
        end
      end
      bits_nxt[j] = b && (3'(j) < n_eff) && (in_opcode == ffce_pkg::OP_ENCODE);
    end

    pack_nxt = '0;
    for (int i = 0; i < NI; i++) begin
      if (3'(i) < k_eff) begin
        pack_nxt = pack_nxt | (32'(sr_nxt[i] & msk[i]) << off[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inputs_r  <= ffce_pkg::RST_NUM_INPUTS;
      num_outputs_r <= ffce_pkg::RST_NUM_OUTPUTS;
      mem_orders_r  <= ffce_pkg::RST_MEM_ORDERS;
      for (int i = 0; i < NI; i++) begin
        gen_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ffce_pkg::CFG_NUM_INPUTS:  num_inputs_r  <= cfg_wdata[2:0];
        ffce_pkg::CFG_NUM_OUTPUTS: num_outputs_r <= cfg_wdata[2:0];
        ffce_pkg::CFG_MEM_ORDERS:  mem_orders_r  <= cfg_wdata[15:0];
        ffce_pkg::CFG_GEN_INPUT0:  gen_r[0]      <= cfg_wdata;
        ffce_pkg::CFG_GEN_INPUT1:  gen_r[1]      <= cfg_wdata;
        ffce_pkg::CFG_GEN_INPUT2:  gen_r[2]      <= cfg_wdata;
        ffce_pkg::CFG_GEN_INPUT3:  gen_r[3]      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NI; i++) begin
        sr_r[i] <= '0;
      end
    end else if (in_acc) begin
      for (int i = 0; i < NI; i++) begin
        sr_r[i] <= sr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_bits_r  <= skid_bits_r;
        out_state_r <= skid_state_r;
      end
    end else if (in_acc) begin
      if (out_free) begin
        out_bits_r  <= bits_nxt;
        out_state_r <= pack_nxt;
      end else begin
        skid_bits_r  <= bits_nxt;
        skid_state_r <= pack_nxt;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while the result register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_stall && out_valid_r && in_valid))
    else $error("skid filled without a stalled result");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && out_valid_r)
    else $error("skid beat not moved to the result register");

endmodule

FILE: dv/feedforward_conv_encoder_top_test.sv
module feedforward_conv_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ffce_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 100;

  typedef struct packed {
    logic [3:0]  coded;
    logic [31:0] state;
  } codeword_t;

  class enc_scoreboard;
    logic [2:0]  num_in_r;
    logic [2:0]  num_out_r;
    logic [15:0] orders_r;
    ffce_pkg::gen_t  gens [ffce_pkg::MAX_INPUTS];
    ffce_pkg::sreg_t regs [ffce_pkg::MAX_INPUTS];
    codeword_t   codeword_q [$];
    int          errors;

    function new();
      num_in_r  = ffce_pkg::RST_NUM_INPUTS;
      num_out_r = ffce_pkg::RST_NUM_OUTPUTS;
      orders_r  = ffce_pkg::RST_MEM_ORDERS;
      for (int i = 0; i < ffce_pkg::MAX_INPUTS; i++) begin
        gens[i] = '0;
        regs[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [ffce_pkg::CFG_IDX_W-1:0] idx, ffce_pkg::gen_t d);
      case (idx)
        ffce_pkg::CFG_NUM_INPUTS:  num_in_r  = d[2:0];
        ffce_pkg::CFG_NUM_OUTPUTS: num_out_r = d[2:0];
        ffce_pkg::CFG_MEM_ORDERS:  orders_r  = d[15:0];
        ffce_pkg::CFG_GEN_INPUT0:  gens[0]   = d;
        ffce_pkg::CFG_GEN_INPUT1:  gens[1]   = d;
        ffce_pkg::CFG_GEN_INPUT2:  gens[2]   = d;
        ffce_pkg::CFG_GEN_INPUT3:  gens[3]   = d;
        default: ;
      endcase
    endfunction

    function int clamp_count(logic [2:0] v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_order(int i);
      int f;
      f = orders_r[4*i +: 4];
      if (f == 0) f = 1;
      else if (f > ffce_pkg::MAX_ORDER) f = ffce_pkg::MAX_ORDER;
      return f;
    endfunction

    function logic [8:0] low_bits(int o);
      return 9'((1 << o) - 1);
    endfunction

    // expected coded bits and packed state after one accepted beat
    function void predict_codeword(ffce_pkg::opcode_t op, logic [3:0] bits, logic [31:0] sv);
      int k, n, o;
      logic [8:0]  win [ffce_pkg::MAX_INPUTS];
      logic [31:0] rest;
      logic [63:0] acc;
      logic [3:0]  coded;
      logic        b;
      k = clamp_count(num_in_r, ffce_pkg::MAX_INPUTS);
      n = clamp_count(num_out_r, ffce_pkg::MAX_OUTPUTS);
      coded = '0;
      if (op == ffce_pkg::OP_LOAD) begin
        rest = sv;
        for (int i = 0; i < k; i++) begin
          o = eff_order(i);
          regs[i] = 8'(9'(rest) & low_bits(o));
          rest = rest >> o;
        end
      end else begin
        for (int i = 0; i < k; i++) begin
          o = eff_order(i);
          win[i] = (((9'(regs[i]) & low_bits(o)) << 1) | 9'(bits[i])) & low_bits(o + 1);
          regs[i] = 8'(win[i] & low_bits(o));
        end
        for (int j = 0; j < n; j++) begin
          b = 1'b0;
          for (int i = 0; i < k; i++) b = b ^ (^(win[i] & gens[i][9*j +: 9]));
          coded[j] = b;
        end
      end
      acc = '0;
      for (int i = k - 1; i >= 0; i--) begin
        o = eff_order(i);
        acc = (acc << o) | 64'(9'(regs[i]) & low_bits(o));
      end
      codeword_q.push_back('{coded, acc[31:0]});
    endfunction

    function void check_codeword(logic [3:0] coded, logic [31:0] state);
      codeword_t exp_cw;
      if (codeword_q.size() == 0) begin
        $display("%0t ns: unexpected result, actual bits %h state %h", $time, coded, state);
        errors++;
        return;
      end
      exp_cw = codeword_q.pop_front();
      if (coded !== exp_cw.coded) begin
        $display("%0t ns: coded bits mismatch, expected %h, actual %h",
                 $time, exp_cw.coded, coded);
        errors++;
      end
      if (state !== exp_cw.state) begin
        $display("%0t ns: packed state mismatch, expected %h, actual %h",
                 $time, exp_cw.state, state);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [ffce_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  ffce_pkg::gen_t                  cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_opcode = ffce_pkg::OP_ENCODE;
  logic [3:0]                      in_in_bits = '0;
  logic [31:0]                     in_state_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [3:0]                      out_out_bits;
  logic [31:0]                     out_packed_state;

  enc_scoreboard sb;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  feedforward_conv_encoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_in_bits       (in_in_bits),
    .in_state_value   (in_state_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_bits     (out_out_bits),
    .out_packed_state (out_packed_state)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off when asked
  initial forever begin
    @(posedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_codeword(out_out_bits, out_packed_state);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // leaves valid high after the beat is taken; the caller lowers it
  task automatic send_beat(ffce_pkg::opcode_t op, logic [3:0] bits, logic [31:0] sv);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_in_bits     <= bits;
    in_state_value <= sv;
    do @(posedge clk); while (in_stall);
    sb.predict_codeword(op, bits, sv);
  endtask

  task automatic random_beat();
    ffce_pkg::opcode_t op;
    logic [31:0] sv;
    if ($urandom_range(99) < 15) op = ffce_pkg::OP_LOAD;
    else op = ffce_pkg::OP_ENCODE;
    sv = ($urandom_range(9) == 0) ? '1 : 32'($urandom);
    send_beat(op, 4'($urandom_range(15)), sv);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.codeword_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ffce_pkg::CFG_IDX_W-1:0] idx, ffce_pkg::gen_t d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  // junk in the unused upper data bits must be ignored
  task automatic set_config(logic [2:0] n_in, logic [2:0] n_out, logic [15:0] ord,
                            ffce_pkg::gen_t g0, ffce_pkg::gen_t g1,
                            ffce_pkg::gen_t g2, ffce_pkg::gen_t g3, bit stray);
    ffce_pkg::gen_t junk;
    if (stray) cfg_write(CFG_IDX_NONE, ffce_pkg::gen_t'({$urandom, $urandom}));
    junk = ffce_pkg::gen_t'({$urandom, $urandom});
    cfg_write(ffce_pkg::CFG_NUM_INPUTS, {junk[35:3], n_in});
    junk = ffce_pkg::gen_t'({$urandom, $urandom});
    cfg_write(ffce_pkg::CFG_NUM_OUTPUTS, {junk[35:3], n_out});
    junk = ffce_pkg::gen_t'({$urandom, $urandom});
    cfg_write(ffce_pkg::CFG_MEM_ORDERS, {junk[35:16], ord});
    cfg_write(ffce_pkg::CFG_GEN_INPUT0, g0);
    cfg_write(ffce_pkg::CFG_GEN_INPUT1, g1);
    cfg_write(ffce_pkg::CFG_GEN_INPUT2, g2);
    cfg_write(ffce_pkg::CFG_GEN_INPUT3, g3);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic randomize_config();
    logic [2:0]  n_in, n_out;
    logic [15:0] ord;
    ffce_pkg::gen_t g [ffce_pkg::MAX_INPUTS];
    n_in  = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    n_out = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    for (int i = 0; i < ffce_pkg::MAX_INPUTS; i++) begin
      ord[4*i +: 4] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(8, 1));
      g[i] = ffce_pkg::gen_t'({$urandom, $urandom});
    end
    set_config(n_in, n_out, ord, g[0], g[1], g[2], g[3], $urandom_range(3) == 0);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one input of order 1, generators all zero
    send_beat(ffce_pkg::OP_ENCODE, 4'hF, 32'($urandom));
    drain();

    // four inputs, orders 8 / zero field / 3 / field above max
    set_config(3'd4, 3'd4, 16'hF308, '1, ffce_pkg::gen_t'({$urandom, $urandom}),
               ffce_pkg::gen_t'({$urandom, $urandom}),
               ffce_pkg::gen_t'({$urandom, $urandom}), 1'b0);
    send_beat(ffce_pkg::OP_LOAD, 4'h0, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'hF, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h0, '1);
    send_beat(ffce_pkg::OP_ENCODE, 4'h1, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h2, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h4, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h8, 32'h0);
    // bits above the total state width are dropped
    send_beat(ffce_pkg::OP_LOAD, 4'hF, '1);
    send_beat(ffce_pkg::OP_ENCODE, 4'h0, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h0, 32'h0);
    send_beat(ffce_pkg::OP_LOAD, 4'h0, 32'($urandom));
    send_beat(ffce_pkg::OP_ENCODE, 4'hF, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'hA, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h5, 32'h0);
    drain();

    // input count above range, output count zero, full 32-bit state, write to an unknown index
    set_config(3'd7, 3'd0, 16'h8888, '1, '0, '1,
               ffce_pkg::gen_t'({$urandom, $urandom}), 1'b1);
    send_beat(ffce_pkg::OP_LOAD, 4'h0, '1);
    send_beat(ffce_pkg::OP_ENCODE, 4'h0, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'hF, 32'h0);
    send_beat(ffce_pkg::OP_LOAD, 4'h0, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h5, 32'h0);
    drain();

    // zero input count, output count above range, all order fields zero; inputs 1..3 keep their registers
    set_config(3'd0, 3'd7, 16'h0000, ffce_pkg::gen_t'({$urandom, $urandom}),
               '1, '1, '1, 1'b0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h1, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'hF, 32'h0);
    send_beat(ffce_pkg::OP_ENCODE, 4'h0, 32'h0);
    drain();

    for (int seg = 0; seg < 16; seg++) begin
      randomize_config();
      if (seg < 5) begin
        src_idle_pct = 34;
        snk_idle_pct = 76;
      end else if (seg < 10) begin
        src_idle_pct = 76;
        snk_idle_pct = 34;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // receiver holds off while beats keep coming, so the input side backs up
      if (seg == 12) hold_req = 1'b1;
      repeat (50) random_beat();
      drain();
    end

    if (sb.errors == 0 && sb.codeword_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ffce_pkg.sv
design/feedforward_conv_encoder_top.sv
dv/feedforward_conv_encoder_top_test.sv
